FILE: design/gdad_pkg.sv
// Package for the Gregorian date adder: shared types, codes and calendar helpers.
// No dependencies; used by every module of the block.
`timescale 1ns / 1ps

package gdad_pkg;

   localparam int YEAR_W  = 12;
   localparam int MONTH_W = 4;
   localparam int DAY_W   = 5;
   localparam int DAYS_W  = 12;
   localparam int STS_W   = 3;
   localparam int CSR_IDX_W = 1;

   // config register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_MIN_YEAR = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_YEAR = 1'b1;

   localparam logic [YEAR_W-1:0] MIN_YEAR_RST = 12'd1601;
   localparam logic [YEAR_W-1:0] MAX_YEAR_RST = 12'd3000;

   // result status codes
   localparam logic [STS_W-1:0] STS_OK        = 3'd0;
   localparam logic [STS_W-1:0] STS_BAD_YEAR  = 3'd1;
   localparam logic [STS_W-1:0] STS_BAD_MONTH = 3'd2;
   localparam logic [STS_W-1:0] STS_BAD_DAY   = 3'd3;
   localparam logic [STS_W-1:0] STS_PAST_MAX  = 3'd4;

   localparam logic [MONTH_W-1:0] MONTH_JAN = 4'd1;
   localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;
   localparam logic [MONTH_W-1:0] MONTH_APR = 4'd4;
   localparam logic [MONTH_W-1:0] MONTH_JUN = 4'd6;
   localparam logic [MONTH_W-1:0] MONTH_SEP = 4'd9;
   localparam logic [MONTH_W-1:0] MONTH_NOV = 4'd11;
   localparam logic [MONTH_W-1:0] MONTH_DEC = 4'd12;

   // floor(y / 25) = (y * DIV25_MUL) >> DIV25_SHIFT, exact for 12-bit y
   localparam int DIV25_SHIFT = 15;
   localparam logic [10:0] DIV25_MUL = 11'd1311;
   localparam int QUOT_W = 8;
   localparam int MOD25_W = 5;
   localparam logic [MOD25_W-1:0] MOD25_LAST = 5'd24;

   typedef enum logic [2:0] {
      S_IDLE,
      S_DIV,
      S_CHECK,
      S_WALK,
      S_DONE
   } state_type;

   typedef struct packed {
      logic load;
      logic div;
      logic check;
      logic step;
      logic out_load;
   } cmd_type;

   typedef struct packed {
      logic walk_done;
   } sts_type;

   // leap: divisible by 4 and (not by 25, or by 16) -- same as the 4/100/400 rule
   function automatic logic is_leap(input logic [YEAR_W-1:0] year,
                                    input logic [MOD25_W-1:0] mod25);
      is_leap = (year[1:0] == 2'b00) && ((mod25 != '0) || (year[3:0] == 4'b0000));
   endfunction

   function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] month,
                                                  input logic leap);
      logic [DAY_W-1:0] len;
      case (month)
         MONTH_APR, MONTH_JUN, MONTH_SEP, MONTH_NOV: len = 5'd30;
         MONTH_FEB: len = leap ? 5'd29 : 5'd28;
         default:   len = 5'd31;
      endcase
      return len;
   endfunction

endpackage

FILE: design/gdad_csr.sv
// Configuration registers (year bounds) of the Gregorian date adder.
// Depends on gdad_pkg.
`timescale 1ns / 1ps

module gdad_csr (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [gdad_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [gdad_pkg::YEAR_W-1:0]    csr_wdata,
   output logic [gdad_pkg::YEAR_W-1:0]    min_year,
   output logic [gdad_pkg::YEAR_W-1:0]    max_year
);
   import gdad_pkg::*;

   logic [YEAR_W-1:0] min_year_ff, min_year_in;
   logic [YEAR_W-1:0] max_year_ff, max_year_in;

   assign csr_ready = 1'b1;

   always_comb begin
      min_year_in = min_year_ff;
      max_year_in = max_year_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_MIN_YEAR: min_year_in = csr_wdata;
            CSR_MAX_YEAR: max_year_in = csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         min_year_ff <= MIN_YEAR_RST;
         max_year_ff <= MAX_YEAR_RST;
      end else begin
         min_year_ff <= min_year_in;
         max_year_ff <= max_year_in;
      end
   end

   assign min_year = min_year_ff;
   assign max_year = max_year_ff;

endmodule

FILE: design/gdad_ctrl.sv
// Controller state machine of the Gregorian date adder.
// Depends on gdad_pkg; drives the datapath through cmd_type, reads sts_type.
`timescale 1ns / 1ps

module gdad_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output gdad_pkg::cmd_type cmd,
   input  gdad_pkg::sts_type sts
);
   import gdad_pkg::*;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      cmd          = '0;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = S_DIV;
            end
         end
         S_DIV: begin
            cmd.div  = 1'b1;
            state_in = S_CHECK;
         end
         S_CHECK: begin
            cmd.check = 1'b1;
            state_in  = S_WALK;
         end
         S_WALK: begin
            if (sts.walk_done) begin
               state_in = S_DONE;
            end else begin
               cmd.step = 1'b1;
            end
         end
         S_DONE: begin
            // output slot free or draining this cycle
            if (!rsp_valid_ff || !rsp_stall) begin
               cmd.out_load = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

FILE: design/gdad_dp.sv
// Datapath of the Gregorian date adder: date check, month walk, output register.
// Depends on gdad_pkg; sequenced by gdad_ctrl.
`timescale 1ns / 1ps

module gdad_dp (
   input  logic                         clock,
   input  gdad_pkg::cmd_type            cmd,
   output gdad_pkg::sts_type            sts,
   input  logic [gdad_pkg::YEAR_W-1:0]  min_year,
   input  logic [gdad_pkg::YEAR_W-1:0]  max_year,
   input  logic [gdad_pkg::YEAR_W-1:0]  req_start_year,
   input  logic [gdad_pkg::MONTH_W-1:0] req_start_month,
   input  logic [gdad_pkg::DAY_W-1:0]   req_start_day,
   input  logic [gdad_pkg::DAYS_W-1:0]  req_days_to_add,
   output logic [gdad_pkg::YEAR_W-1:0]  rsp_result_year,
   output logic [gdad_pkg::MONTH_W-1:0] rsp_result_month,
   output logic [gdad_pkg::DAY_W-1:0]   rsp_result_day,
   output logic [gdad_pkg::STS_W-1:0]   rsp_status
);
   import gdad_pkg::*;

   localparam int PROD_W = YEAR_W + 11;

   logic [YEAR_W-1:0]  year_ff, year_in;
   logic [MONTH_W-1:0] month_ff, month_in;
   logic [DAY_W-1:0]   day_ff, day_in;
   logic [DAYS_W-1:0]  rem_ff, rem_in;
   logic [QUOT_W-1:0]  quot_ff, quot_in;
   logic [MOD25_W-1:0] mod25_ff, mod25_in;
   logic [STS_W-1:0]   status_ff, status_in;

   logic [YEAR_W-1:0]  out_year_ff;
   logic [MONTH_W-1:0] out_month_ff;
   logic [DAY_W-1:0]   out_day_ff;
   logic [STS_W-1:0]   out_status_ff;

   logic [PROD_W-1:0]  prod;
   logic [YEAR_W-1:0]  quot_x25;
   logic [YEAR_W-1:0]  rem25_wide;
   logic [MOD25_W-1:0] rem25;
   logic [DAY_W-1:0]   chk_len;
   logic [DAY_W-1:0]   walk_len;
   logic [DAYS_W:0]    day_sum;
   logic [DAY_W:0]     used;
   logic [YEAR_W:0]    year_inc;

   // y / 25 by reciprocal multiply, registered before use
   assign prod = PROD_W'(year_ff) * PROD_W'(DIV25_MUL);

   // y mod 25 = y - 25 * q, q * 25 as shift-add
   assign quot_x25   = (YEAR_W'(quot_ff) << 4) + (YEAR_W'(quot_ff) << 3) + YEAR_W'(quot_ff);
   assign rem25_wide = year_ff - quot_x25;
   assign rem25      = rem25_wide[MOD25_W-1:0];

   assign chk_len  = month_len(month_ff, is_leap(year_ff, rem25));
   assign walk_len = month_len(month_ff, is_leap(year_ff, mod25_ff));
   assign day_sum  = (DAYS_W+1)'(rem_ff) + (DAYS_W+1)'(day_ff);
   assign used     = (DAY_W+1)'(walk_len) - (DAY_W+1)'(day_ff) + (DAY_W+1)'(1);
   assign year_inc = (YEAR_W+1)'(year_ff) + (YEAR_W+1)'(1);

   assign sts.walk_done = (rem_ff == '0) || (status_ff != STS_OK);

   always_comb begin
      year_in   = year_ff;
      month_in  = month_ff;
      day_in    = day_ff;
      rem_in    = rem_ff;
      quot_in   = quot_ff;
      mod25_in  = mod25_ff;
      status_in = status_ff;
      if (cmd.load) begin
         year_in   = req_start_year;
         month_in  = req_start_month;
         day_in    = req_start_day;
         rem_in    = req_days_to_add;
         status_in = STS_OK;
      end
      if (cmd.div) begin
         quot_in = prod[DIV25_SHIFT +: QUOT_W];
      end
      if (cmd.check) begin
         mod25_in = rem25;
         if (year_ff < min_year || year_ff > max_year) begin
            status_in = STS_BAD_YEAR;
         end else if (month_ff < MONTH_JAN || month_ff > MONTH_DEC) begin
            status_in = STS_BAD_MONTH;
         end else if (day_ff == '0 || day_ff > chk_len) begin
            status_in = STS_BAD_DAY;
         end
         // rejected dates report an all-zero date
         if (status_in != STS_OK) begin
            year_in  = '0;
            month_in = '0;
            day_in   = '0;
         end
      end
      if (cmd.step) begin
         if (day_sum > (DAYS_W+1)'(walk_len)) begin
            // finish this month, move to day 1 of the next
            rem_in = rem_ff - DAYS_W'(used);
            day_in = DAY_W'(1);
            if (month_ff != MONTH_DEC) begin
               month_in = month_ff + MONTH_W'(1);
            end else begin
               month_in = MONTH_JAN;
               year_in  = year_inc[YEAR_W-1:0];
               mod25_in = (mod25_ff == MOD25_LAST) ? '0 : mod25_ff + MOD25_W'(1);
               if (year_inc > (YEAR_W+1)'(max_year)) begin
                  status_in = STS_PAST_MAX;
               end
            end
         end else begin
            day_in = day_sum[DAY_W-1:0];
            rem_in = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      year_ff   <= year_in;
      month_ff  <= month_in;
      day_ff    <= day_in;
      rem_ff    <= rem_in;
      quot_ff   <= quot_in;
      mod25_ff  <= mod25_in;
      status_ff <= status_in;
      if (cmd.out_load) begin
         out_year_ff   <= year_ff;
         out_month_ff  <= month_ff;
         out_day_ff    <= day_ff;
         out_status_ff <= status_ff;
      end
   end

   assign rsp_result_year  = out_year_ff;
   assign rsp_result_month = out_month_ff;
   assign rsp_result_day   = out_day_ff;
   assign rsp_status       = out_status_ff;

endmodule

FILE: design/gregorian_date_add_days.sv
// Gregorian date adder: adds a day count to a checked start date, one month per cycle.
// An item is taken when req_valid is high and req_stall low; the beat
// then passes through a load, the divide-by-25 multiply, the date check,
// one step per month walked, a step to see the walk end and a move of
// the result into the output register. The month walk dominates the time
// taken. A result waits in the output register until rsp_stall is low,
// while the next beat may already be in work. Status: 0 ok, 1 year outside
// min_year..max_year, 2 month outside 1..12, 3 day outside the month, 4 walk
// ran past max_year (result is January 1 of max_year + 1, wrapped to 12
// bits). Rejected dates give an all-zero date. Year bounds are written
// through the csr port; the user must write them only while idle, as the
// block itself does not enforce it.
// Depends on gdad_pkg, gdad_csr, gdad_ctrl and gdad_dp.
`timescale 1ns / 1ps

module gregorian_date_add_days (
   input  logic                           clock,
   input  logic                           reset,
   // configuration writes
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [gdad_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [gdad_pkg::YEAR_W-1:0]    csr_wdata,
   // request beat
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic [gdad_pkg::YEAR_W-1:0]    req_start_year,
   input  logic [gdad_pkg::MONTH_W-1:0]   req_start_month,
   input  logic [gdad_pkg::DAY_W-1:0]     req_start_day,
   input  logic [gdad_pkg::DAYS_W-1:0]    req_days_to_add,
   // response beat
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic [gdad_pkg::YEAR_W-1:0]    rsp_result_year,
   output logic [gdad_pkg::MONTH_W-1:0]   rsp_result_month,
   output logic [gdad_pkg::DAY_W-1:0]     rsp_result_day,
   output logic [gdad_pkg::STS_W-1:0]     rsp_status
);
   import gdad_pkg::*;

   logic [YEAR_W-1:0] min_year;
   logic [YEAR_W-1:0] max_year;
   cmd_type           cmd;
   sts_type           sts;

   // year bounds
   gdad_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .min_year  (min_year),
      .max_year  (max_year)
   );

   // sequencing: load, divide, check, walk, hand off
   gdad_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd),
      .sts       (sts)
   );

   // working date registers, month stepper and output register
   gdad_dp u_dp (
      .clock            (clock),
      .cmd              (cmd),
      .sts              (sts),
      .min_year         (min_year),
      .max_year         (max_year),
      .req_start_year   (req_start_year),
      .req_start_month  (req_start_month),
      .req_start_day    (req_start_day),
      .req_days_to_add  (req_days_to_add),
      .rsp_result_year  (rsp_result_year),
      .rsp_result_month (rsp_result_month),
      .rsp_result_day   (rsp_result_day),
      .rsp_status       (rsp_status)
   );

`ifndef SYNTHESIS
   // one beat in work at a time: after a take, the input stalls
   a_busy_after_take: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("request taken while previous beat still in work");

   // rejected dates carry an all-zero date
   a_bad_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_status == STS_BAD_YEAR || rsp_status == STS_BAD_MONTH ||
                     rsp_status == STS_BAD_DAY))
      |-> (rsp_result_year == '0 && rsp_result_month == '0 && rsp_result_day == '0))
      else $error("rejected date with nonzero result fields");

   // good results are real calendar positions
   a_ok_range: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status == STS_OK)
      |-> (rsp_result_month >= MONTH_JAN && rsp_result_month <= MONTH_DEC &&
           rsp_result_day != '0))
      else $error("ok result outside calendar range");

   // past-max results land on January 1
   a_past_max: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status == STS_PAST_MAX)
      |-> (rsp_result_month == MONTH_JAN && rsp_result_day == DAY_W'(1)))
      else $error("past-max result not on January 1");
`endif

endmodule
